/* rtl/scs_pkg.sv */
// Shared types and constants of the scene change score block.
`timescale 1ns / 1ps

package scs_pkg;

  // One pixel pair, co-located in the previous and the current frame.
  typedef struct packed {
    logic [7:0] previous_pixel;
    logic [7:0] current_pixel;
  } pixel_pair_t;

  // One result per completed frame.
  typedef struct packed {
    logic [31:0] frame_sad;
    logic [15:0] mean_difference;
    logic [16:0] change_score;
  } frame_result_t;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned ADDR_W = 3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [DIM_W-1:0] DIM_MAX            = 13'd4096;

  // The score is m * 256 / 100 = (m * 64) / 25. The division by 25 is a
  // multiplication by ceil(2^26 / 25) and a shift by 26, exact for any
  // dividend below 2^22.
  localparam logic [21:0] SCORE_RECIP       = 22'd2684355;
  localparam int unsigned SCORE_RECIP_SHIFT = 26;
  // m at or above this value gives a score of one or more.
  localparam logic [15:0] SCORE_SAT_LIMIT = 16'd25600;
  localparam logic [16:0] SCORE_ONE       = 17'd65536;
  localparam logic [15:0] MEAN_MAX        = 16'hFFFF;

endpackage

/* rtl/scene_change_score_top.sv */
// Scene change score: SAD accumulation, MAFD by shift-subtract division and score by a reciprocal multiplication.
`timescale 1ns / 1ps

// Pixel pairs of the previous and the current frame arrive in raster order, one
// beat per pair. Every pair that is not the last of its frame leaves in_ready
// high for the next pair. The last pair of a frame (frame_width * frame_height
// pixels, each dimension clamped to 1..4096) starts the end-of-frame work,
// during which in_ready is low: restoring division for the MAFD (DIV_MEAN),
// forming the score operand (SCORE_SETUP), the score, a multiplication by the
// reciprocal of 25 (SCORE_MUL), and loading the result (FINISH), which waits
// while an earlier result still sits in the output register.
// The MAFD division runs on a shift-subtract unit, one quotient bit per cycle.
// Pixel beats are accepted while a result waits to be taken. The MAFD is Q8.8,
// sad * 256 / n truncated and saturated at 0xFFFF; the score is
// min(mafd, |mafd - previous mafd|) / 100 in Q0.16, truncated and saturated at
// 65536. The first frame after reset compares against a previous MAFD of
// zero. Writes to frame_width (address 0) and frame_height (address 4) take
// effect at once and belong in idle periods.
module scene_change_score_top (
  input  logic                       clk,
  input  logic                       rst,
  // Pixel pair input channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  scs_pkg::pixel_pair_t       in_data,
  // Result output channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output scs_pkg::frame_result_t     out_data,
  // APB configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  typedef enum logic [2:0] {
    IDLE,
    DIV_MEAN,
    SCORE_SETUP,
    SCORE_MUL,
    FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [scs_pkg::DIM_W-1:0] frame_width;
  logic [scs_pkg::DIM_W-1:0] frame_height;

  // Frame accumulators and the MAFD kept from the last frame.
  logic [31:0] difference_sum;
  logic [23:0] pixel_count;
  logic [15:0] last_frame_mean;

  // Divider registers: partial remainder, numerator bits still to be
  // shifted in, quotient and the step counter.
  logic [23:0] remainder;
  logic [15:0] numerator;
  logic [15:0] quotient;
  logic [3:0]  step;
  logic [24:0] pixel_total;
  logic        saturate;
  logic [15:0] frame_mean;
  logic [15:0] score_term;
  logic [16:0] score_result;

  logic                      cfg_write;
  logic                      in_fire;
  logic [scs_pkg::DIM_W-1:0] width_clamped;
  logic [scs_pkg::DIM_W-1:0] height_clamped;
  logic [24:0]               frame_size;
  logic [7:0]                pixel_diff;
  logic [31:0]               sum_next;
  logic [24:0]               count_plus_one;
  logic                      frame_last;

  logic [24:0] shifted_rem;
  logic        rem_ge;
  logic [24:0] rem_diff;

  logic [15:0] mean_value;
  logic [15:0] mean_delta;
  logic [15:0] min_term;
  logic [43:0] score_product;
  logic [16:0] score_value;
  logic        out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (state == IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (paddr[2])
      scs_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, frame_width};
      scs_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height};
      default:                   prdata = 32'd0;
    endcase
  end

  // A dimension of zero counts as one and anything above 4096 as 4096.
  always_comb begin
    width_clamped  = frame_width;
    height_clamped = frame_height;
    if (frame_width == '0) begin
      width_clamped = 13'd1;
    end else if (frame_width > scs_pkg::DIM_MAX) begin
      width_clamped = scs_pkg::DIM_MAX;
    end
    if (frame_height == '0) begin
      height_clamped = 13'd1;
    end else if (frame_height > scs_pkg::DIM_MAX) begin
      height_clamped = scs_pkg::DIM_MAX;
    end
  end

  assign frame_size = {12'd0, width_clamped} * {12'd0, height_clamped};

  // Per-pixel accumulation and end-of-frame detection.
  always_comb begin
    if (in_data.previous_pixel > in_data.current_pixel) begin
      pixel_diff = in_data.previous_pixel - in_data.current_pixel;
    end else begin
      pixel_diff = in_data.current_pixel - in_data.previous_pixel;
    end
    sum_next       = difference_sum + {24'd0, pixel_diff};
    count_plus_one = {1'b0, pixel_count} + 25'd1;
    frame_last     = (count_plus_one >= frame_size);
  end

  // The shift-subtract step. Unless the MAFD saturates, the remainder stays below
  // the divisor, so the shifted value fits in 25 bits.
  always_comb begin
    shifted_rem = {remainder, numerator[15]};
    rem_ge      = (shifted_rem >= pixel_total);
    rem_diff    = shifted_rem - pixel_total;
  end

  // Score operands, formed once the MAFD quotient is complete.
  always_comb begin
    mean_value = saturate ? scs_pkg::MEAN_MAX : quotient;
    if (mean_value > last_frame_mean) begin
      mean_delta = mean_value - last_frame_mean;
    end else begin
      mean_delta = last_frame_mean - mean_value;
    end
    min_term      = (mean_value < mean_delta) ? mean_value : mean_delta;
    score_product = {22'd0, score_term, 6'd0} * {22'd0, scs_pkg::SCORE_RECIP};
    score_value   = saturate ? scs_pkg::SCORE_ONE
                             : {1'b0, score_product[scs_pkg::SCORE_RECIP_SHIFT+15:
                                                    scs_pkg::SCORE_RECIP_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      frame_width     <= scs_pkg::FRAME_WIDTH_RESET;
      frame_height    <= scs_pkg::FRAME_HEIGHT_RESET;
      difference_sum  <= '0;
      pixel_count     <= '0;
      last_frame_mean <= '0;
      out_valid       <= 1'b0;
      step            <= '0;
      saturate        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          scs_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[scs_pkg::DIM_W-1:0];
          scs_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[scs_pkg::DIM_W-1:0];
          default: ;
        endcase
      end

      // A result taken while a new one is loaded is replaced in FINISH.
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_fire) begin
            difference_sum <= sum_next;
            if (frame_last) begin
              // The quotient of sum * 256 / n fits in 16 bits exactly when
              // sum / 256 is below n; otherwise the MAFD saturates.
              pixel_total <= count_plus_one;
              remainder   <= sum_next[31:8];
              numerator   <= {sum_next[7:0], 8'd0};
              saturate    <= ({1'b0, sum_next[31:8]} >= count_plus_one);
              step        <= 4'd15;
              state       <= DIV_MEAN;
            end else begin
              pixel_count <= count_plus_one[23:0];
            end
          end
        end
        DIV_MEAN: begin
          remainder <= rem_ge ? rem_diff[23:0] : shifted_rem[23:0];
          numerator <= {numerator[14:0], 1'b0};
          quotient  <= {quotient[14:0], rem_ge};
          step      <= step - 4'd1;
          if (step == '0) begin
            state <= SCORE_SETUP;
          end
        end
        SCORE_SETUP: begin
          // Below 25600, m * 64 / 25 stays under 65536.
          frame_mean <= mean_value;
          score_term <= min_term;
          saturate   <= (min_term >= scs_pkg::SCORE_SAT_LIMIT);
          state      <= SCORE_MUL;
        end
        SCORE_MUL: begin
          score_result <= score_value;
          state        <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.frame_sad       <= difference_sum;
            out_data.mean_difference <= frame_mean;
            out_data.change_score    <= score_result;
            last_frame_mean          <= frame_mean;
            difference_sum           <= '0;
            pixel_count              <= '0;
            state                    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the scene change score block.
`timescale 1ns / 1ps

module tb_top;

  // Frame content patterns used to steer the mean difference and the score.
  typedef enum int unsigned {
    CONTENT_NOISE,    // independent random pixels
    CONTENT_STILL,    // both frames equal, no difference at all
    CONTENT_EXTREME,  // black against white, largest difference
    CONTENT_NEAR,     // small differences around a random level
    CONTENT_FLAT      // one fixed pair repeated over the whole frame
  } content_e;

  localparam logic [scs_pkg::DIM_W-1:0] DIM_ALL_ONES = 13'h1FFF;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned QUIET_LIMIT      = 2000;
  localparam int unsigned RANDOM_PAIRS     = 1660;
  localparam int unsigned CALM_TAIL_PAIRS  = 250;

  // Every input of the block starts at a known value.
  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  scs_pkg::pixel_pair_t   in_data  = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  scs_pkg::frame_result_t out_data;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [scs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  scene_change_score_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Pixel pairs waiting to be offered, and the frame results still owed by
  // the block, oldest first.
  scs_pkg::pixel_pair_t   pixel_queue[$];
  scs_pkg::frame_result_t expected_frames[$];

  // Pairs queued by the stimulus and pairs taken by the block. Each counter
  // has a single writer; their difference is the work not yet accepted.
  int unsigned pairs_queued = 0;
  int unsigned pairs_taken  = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Idling control. idle_en enables random gaps and stalls; the long hold is
  // requested once by the stimulus and carried out by the result side.
  bit idle_en         = 1'b0;
  bit long_hold_req   = 1'b0;
  bit long_hold_taken = 1'b0;

  // Shadow of the frame size registers and of the accumulation state.
  logic [scs_pkg::DIM_W-1:0] dim_width   = scs_pkg::FRAME_WIDTH_RESET;
  logic [scs_pkg::DIM_W-1:0] dim_height  = scs_pkg::FRAME_HEIGHT_RESET;
  logic [31:0]               sad_total   = '0;
  logic [23:0]               pixels_seen = '0;
  logic [15:0]               last_mean   = '0;

  // A dimension of zero counts as one, anything above the maximum as the
  // maximum, so a frame never holds more than 2^24 pixels.
  function automatic logic [scs_pkg::DIM_W-1:0] clamped_dim(
      input logic [scs_pkg::DIM_W-1:0] d);
    if (d == '0) return 13'd1;
    if (d > scs_pkg::DIM_MAX) return scs_pkg::DIM_MAX;
    return d;
  endfunction

  // Adds one pixel pair to the running frame. On the last pixel of a frame
  // it fills in the frame result, remembers the mean for the next frame and
  // clears the accumulators. A size written in the middle of a frame takes
  // effect at once, so the frame ends on the first pixel whose count of
  // earlier pixels reaches the new size minus one.
  function automatic bit accumulate_pair(input scs_pkg::pixel_pair_t pair,
                                         output scs_pkg::frame_result_t res);
    logic [7:0]  diff;
    logic [25:0] frame_size;
    logic [24:0] pixels;
    logic [39:0] sad_q8;
    logic [39:0] mean_wide;
    logic [15:0] mean;
    logic [15:0] delta;
    logic [15:0] smaller;
    logic [31:0] score;
    res = '0;
    diff = (pair.previous_pixel > pair.current_pixel)
         ? pair.previous_pixel - pair.current_pixel
         : pair.current_pixel - pair.previous_pixel;
    frame_size = 26'(clamped_dim(dim_width)) * 26'(clamped_dim(dim_height));
    sad_total = sad_total + 32'(diff);
    if (26'(pixels_seen) + 26'd1 < frame_size) begin
      pixels_seen = pixels_seen + 24'd1;
      return 1'b0;
    end
    pixels    = 25'(pixels_seen) + 25'd1;
    sad_q8    = {sad_total, 8'd0};
    mean_wide = sad_q8 / 40'(pixels);
    mean      = (mean_wide > 40'(scs_pkg::MEAN_MAX)) ? scs_pkg::MEAN_MAX
                                                     : mean_wide[15:0];
    delta     = (mean > last_mean) ? mean - last_mean : last_mean - mean;
    smaller   = (mean < delta) ? mean : delta;
    score     = {8'd0, smaller, 8'd0} / 32'd100;
    if (score > 32'(scs_pkg::SCORE_ONE)) score = 32'(scs_pkg::SCORE_ONE);
    res.frame_sad       = sad_total;
    res.mean_difference = mean;
    res.change_score    = score[16:0];
    last_mean   = mean;
    sad_total   = '0;
    pixels_seen = '0;
    return 1'b1;
  endfunction

  // Pixel driver. The prediction runs on the beat that is accepted at this
  // edge, then the next beat is chosen. A beat on offer is held unchanged
  // until taken; gaps only fall between beats.
  int unsigned gap_left = 0;

  always @(posedge clk) begin : pixel_driver
    scs_pkg::frame_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (accumulate_pair(in_data, res)) expected_frames.push_back(res);
        pairs_taken++;
      end
      if (in_valid && !in_ready) begin
        // Keep offering the same beat.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        // This cycle opens a burst of idle cycles of random length.
        gap_left = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_data  <= pixel_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Each frame result taken is compared field by field with
  // the oldest one owed. Ready is lowered in random bursts, and once for a
  // long stretch so that the block has to stall its pixel input.
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk) begin : result_monitor
    scs_pkg::frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("frame result with no frame pending: frame_sad %0d",
                 out_data.frame_sad);
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.frame_sad !== want.frame_sad) begin
            $error("frame_sad: expected %0d, got %0d",
                   want.frame_sad, out_data.frame_sad);
            mismatch_count++;
          end
          if (out_data.mean_difference !== want.mean_difference) begin
            $error("mean_difference: expected %0d, got %0d",
                   want.mean_difference, out_data.mean_difference);
            mismatch_count++;
          end
          if (out_data.change_score !== want.change_score) begin
            $error("change_score: expected %0d, got %0d",
                   want.change_score, out_data.change_score);
            mismatch_count++;
          end
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is lost if nothing moves on any port for too long.
  // The limit covers the long hold, the pauses around register writes and
  // the end-of-frame work several times over.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[scene_change_score_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: a setup cycle, then an access cycle. The register
  // takes the value at the edge that ends the access cycle, and the shadow
  // copy follows at that same edge.
  task automatic write_reg(input logic idx, input logic [scs_pkg::DIM_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == scs_pkg::REG_FRAME_WIDTH) dim_width = value;
    else dim_height = value;
  endtask

  task automatic write_dims(input logic [scs_pkg::DIM_W-1:0] w,
                            input logic [scs_pkg::DIM_W-1:0] h);
    write_reg(scs_pkg::REG_FRAME_WIDTH, w);
    write_reg(scs_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // The phase change is made at the falling edge, away from the sampling edge.
  task automatic start_phase(input bit idle);
    @(negedge clk);
    idle_en = idle;
  endtask

  task automatic queue_pair(input logic [7:0] prev_px, input logic [7:0] cur_px);
    scs_pkg::pixel_pair_t p;
    p.previous_pixel = prev_px;
    p.current_pixel  = cur_px;
    pixel_queue.push_back(p);
    pairs_queued++;
  endtask

  // Queues a run of pixel pairs, all following one content pattern.
  task automatic queue_frame(input int unsigned pixels);
    content_e   content;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    content = content_e'($urandom_range(0, 4));
    a = 8'($urandom);
    b = 8'($urandom);
    repeat (pixels) begin
      case (content)
        CONTENT_NOISE: begin
          a = 8'($urandom);
          b = 8'($urandom);
        end
        CONTENT_STILL: begin
          a = 8'($urandom);
          b = a;
        end
        CONTENT_EXTREME: begin
          if ($urandom_range(0, 1) == 0) begin
            a = 8'hFF;
            b = 8'h00;
          end else begin
            a = 8'h00;
            b = 8'hFF;
          end
        end
        CONTENT_NEAR: begin
          a = 8'($urandom);
          d = 8'($urandom_range(0, 3));
          b = (a > 8'd251) ? a - d : a + d;
        end
        default: begin
          // The fixed pair drawn above stays for the whole run.
        end
      endcase
      queue_pair(a, b);
    end
  endtask

  // Waits until every queued pair has been taken and every owed result has
  // come out, then lets the end-of-frame latency pass so that the block is
  // surely idle before the next register write.
  task automatic wait_until_drained();
    while (pairs_taken != pairs_queued || expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_pairs;
    int unsigned frame_len;
    int unsigned part;
    logic [scs_pkg::DIM_W-1:0] w;
    logic [scs_pkg::DIM_W-1:0] h;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // One-pixel frames: every pair is a whole frame. The first frame is
    // scored against a previous mean of zero. Then no difference, the
    // largest difference in both directions, a mean that jumps back to zero,
    // the smallest nonzero mean, and scores just below and exactly at the
    // saturation point.
    write_dims(13'd1, 13'd1);
    start_phase(1'b0);
    queue_pair(8'd40, 8'd10);
    queue_pair(8'd0, 8'd0);
    queue_pair(8'd255, 8'd0);
    queue_pair(8'd0, 8'd255);
    queue_pair(8'd255, 8'd255);
    queue_pair(8'd1, 8'd0);
    queue_pair(8'd0, 8'd100);
    queue_pair(8'd0, 8'd200);
    queue_pair(8'd0, 8'd201);
    wait_until_drained();

    // Zero dimensions count as one.
    write_dims(13'd0, 13'd0);
    start_phase(1'b1);
    queue_pair(8'd7, 8'd3);
    queue_pair(8'd3, 8'd7);
    wait_until_drained();

    // A 3x2 frame, then part of the next one. The size is raised to the
    // largest frame and then shrunk again in the middle of that frame, so
    // the frame ends on the next pixel with all pixels so far counted.
    write_dims(13'd3, 13'd2);
    start_phase(1'b1);
    queue_pair(8'd10, 8'd20);
    queue_pair(8'd200, 8'd13);
    queue_pair(8'd128, 8'd127);
    queue_pair(8'd0, 8'd255);
    queue_pair(8'd99, 8'd99);
    queue_pair(8'd64, 8'd192);
    queue_pair(8'd5, 8'd6);
    queue_pair(8'd170, 8'd85);
    queue_pair(8'd85, 8'd170);
    wait_until_drained();
    write_dims(scs_pkg::DIM_MAX, scs_pkg::DIM_MAX);
    start_phase(1'b0);
    queue_pair(8'd255, 8'd1);
    queue_pair(8'd2, 8'd254);
    wait_until_drained();
    write_dims(13'd2, 13'd1);
    start_phase(1'b0);
    queue_pair(8'd33, 8'd66);
    wait_until_drained();

    // Back pressure: one-pixel frames keep the block busy while the result
    // side holds off for a long stretch, so the output register fills and
    // the pixel input stalls. The pause before each register write is the
    // other pressure case: the sender waits for every result to come out.
    write_dims(13'd1, 13'd1);
    start_phase(1'b0);
    long_hold_req = 1'b1;
    repeat (24) queue_frame(1);
    wait_until_drained();

    // All-ones dimension values clamp to the maximum, and a zero in the
    // other dimension counts as one, giving frames of 4096 pixels that stay
    // open while a few dozen pixels pass. A small size then ends the frame.
    write_dims(DIM_ALL_ONES, 13'd0);
    start_phase(1'b1);
    queue_frame(20);
    wait_until_drained();
    write_dims(13'd0, DIM_ALL_ONES);
    start_phase(1'b1);
    queue_frame(20);
    wait_until_drained();
    write_dims(13'd2, 13'd1);
    start_phase(1'b0);
    queue_frame(1);
    wait_until_drained();

    // Random part: small frame sizes, a few whole frames each, and often a
    // partial frame left over for the next size to pick up. The last stretch
    // runs without idling.
    random_pairs = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      w = 13'($urandom_range(1, 12));
      h = 13'($urandom_range(1, 6));
      if ($urandom_range(0, 7) == 0) w = '0;
      else if ($urandom_range(0, 7) == 0) h = '0;
      write_dims(w, h);
      start_phase(random_pairs < RANDOM_PAIRS - CALM_TAIL_PAIRS &&
                  $urandom_range(0, 3) != 0);
      frame_len = int'(clamped_dim(w)) * int'(clamped_dim(h));
      repeat ($urandom_range(1, 5)) begin
        queue_frame(frame_len);
        random_pairs += frame_len;
      end
      if (frame_len > 1 && $urandom_range(0, 2) == 0) begin
        part = $urandom_range(1, frame_len - 1);
        queue_frame(part);
        random_pairs += part;
      end
      wait_until_drained();
    end

    if (mismatch_count == 0) begin
      $display("[scene_change_score_top] OK");
    end else begin
      $display("[scene_change_score_top] ERROR");
    end
    $finish;
  end

endmodule
